// File: hw/rtl/hllru_pkg.sv
// ----------------------------------------------------------------------------
// hllru_pkg
// Shared widths, constants, command/status codes and the control and flag
// bundles between the sequencer and the datapath of the HLL register update.
// ----------------------------------------------------------------------------
package hllru_pkg;

    // Field widths of the command and result transactions
    localparam int HASH_W  = 64;
    localparam int INDEX_W = 14;
    localparam int RANK_W  = 6;
    localparam int PREC_W  = 4;
    localparam int STAT_W  = 2;

    // Width of the effective precision, which holds values up to 31
    localparam int EFF_W = 5;

    localparam int MIN_PRECISION     = 4;
    localparam int DEF_MAX_PRECISION = 14;

    localparam logic [PREC_W-1:0] PRECISION_RESET = 4'd14;

    // 64-bit finalizer constants
    localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam int                MIX_SHIFT = 33;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_MERGE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_MISMATCH = 2'd1,
        STAT_RANGE    = 2'd2
    } stat_t;

    // Per-cycle datapath commands issued by the sequencer
    typedef struct packed {
        logic load;      // capture a new transaction
        logic xs;        // k ^= k >> 33
        logic mul_sel;   // 0: first multiplier constant, 1: second
        logic mul_lo;    // low x low partial product
        logic mul_x1;    // accumulate low product, high(k) x low(c)
        logic mul_x2;    // accumulate cross term, low(k) x high(c)
        logic mul_done;  // fold last cross term into k
        logic shift;     // split mixed hash into slot and remainder
        logic lz_bytes;  // per-byte leading zero counts
        logic lz_rank;   // combine byte counts into a rank
        logic rd;        // read the rank store
        logic clr_wr;    // write zero at the sweep address
        logic finish;    // update the register and latch the result
    } ctrl_t;

    // Status back to the sequencer
    typedef struct packed {
        logic bad;       // merge/read rejected (mismatch or range)
        logic clr_last;  // sweep address at the last entry
    } flags_t;

endpackage

// File: hw/rtl/hyperloglog_register_update.sv
// ----------------------------------------------------------------------------
// hyperloglog_register_update
// HyperLogLog register file of 2^precision ranks with add, merge, read and
// clear commands, one result per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on status/slot/value/changed for exactly one cycle with done high, and the
// receiver cannot stall it. After reset the block sweeps the whole rank store
// to zero, one entry per cycle, with busy high. An add runs three xor-shift
// steps, the finalizer's two 64-bit multiplies at four steps each on one
// shared 32x32 multiplier, then three for the leading-zero unit and one for
// the store read-modify-write, and then returns to idle to take the next
// command. Merge and read pass a check step and, unless rejected, an update
// step after the registered store read. Clear sweeps the store with one
// store write per cycle. The result strobe rises the cycle after the last
// busy cycle. The user must write precision only while the block is idle;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hyperloglog_register_update
    import hllru_pkg::*;
#(
    parameter int MAX_PRECISION = DEF_MAX_PRECISION
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [HASH_W-1:0]   hash,
    input  logic [INDEX_W-1:0]  index,
    input  logic [RANK_W-1:0]   peer_rank,
    input  logic [PREC_W-1:0]   peer_precision,
    input  logic                cfg_wr_en,
    input  logic [PREC_W-1:0]   cfg_wr_data,
    output logic                done,
    output logic [STAT_W-1:0]   status,
    output logic [INDEX_W-1:0]  slot,
    output logic [RANK_W-1:0]   value,
    output logic                changed
);

    ctrl_t  ctrl;
    flags_t flags;

    // sequencer
    hllru_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .flags   (flags),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    // datapath and rank store
    hllru_dp #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .command        (command),
        .hash           (hash),
        .index          (index),
        .peer_rank      (peer_rank),
        .peer_precision (peer_precision),
        .ctrl           (ctrl),
        .flags          (flags),
        .status         (status),
        .slot           (slot),
        .value          (value),
        .changed        (changed)
    );

endmodule

// File: hw/rtl/hllru_dp.sv
// ----------------------------------------------------------------------------
// hllru_dp
// Datapath: precision register, hash finalizer on a shared 32x32 multiplier,
// leading-zero rank unit, rank store with registered read, result registers.
// ----------------------------------------------------------------------------
module hllru_dp
    import hllru_pkg::*;
#(
    parameter int MAX_PRECISION = DEF_MAX_PRECISION
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PREC_W-1:0]   cfg_wr_data,
    input  logic [1:0]          command,
    input  logic [HASH_W-1:0]   hash,
    input  logic [INDEX_W-1:0]  index,
    input  logic [RANK_W-1:0]   peer_rank,
    input  logic [PREC_W-1:0]   peer_precision,
    input  ctrl_t               ctrl,
    output flags_t              flags,
    output logic [STAT_W-1:0]   status,
    output logic [INDEX_W-1:0]  slot,
    output logic [RANK_W-1:0]   value,
    output logic                changed
);

    localparam int ADDR_W = MAX_PRECISION;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [EFF_W-1:0] EFF_MIN = EFF_W'(MIN_PRECISION);
    localparam logic [EFF_W-1:0] EFF_MAX = EFF_W'(MAX_PRECISION);

    // count of leading zeros in one byte, 0..8
    function automatic logic [3:0] lzc8(input logic [7:0] b);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int j = 7; j >= 0; j--) begin
            if (!hit && b[j]) begin
                hit = 1'b1;
            end
            if (!hit) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    logic [PREC_W-1:0]  precision_reg;
    cmd_t               cmd_reg;
    logic [HASH_W-1:0]  k_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [RANK_W-1:0]  peer_rank_reg;
    logic [PREC_W-1:0]  peer_prec_reg;
    logic [HASH_W-1:0]  prod_reg;
    logic [HASH_W-1:0]  acc_reg;
    logic [HASH_W-1:0]  rest_reg;
    logic [ADDR_W-1:0]  hslot_reg;
    logic [3:0]         byte_lz_reg [8];
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    stat_t              status_reg;
    logic [INDEX_W-1:0] slot_reg;
    logic [RANK_W-1:0]  value_reg;
    logic               changed_reg;

    logic [RANK_W-1:0]  mem [DEPTH];

    logic [EFF_W-1:0]   eff_p;
    logic [RANK_W-1:0]  max_rank;
    logic [RANK_W-1:0]  peer_sat;
    logic [6:0]         slot_shift;
    logic [HASH_W-1:0]  mul_c;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [HASH_W-1:0]  mul_p;
    logic               mismatch;
    logic               out_of_range;
    logic               bad;
    logic [RANK_W-1:0]  rank_calc;
    logic               rank_found;
    logic [ADDR_W+INDEX_W-1:0] idx_wide;
    logic [ADDR_W+INDEX_W-1:0] hslot_wide;
    logic [ADDR_W-1:0]  idx_addr;
    logic [ADDR_W-1:0]  acc_addr;
    logic [INDEX_W-1:0] hslot_out;
    logic [RANK_W-1:0]  cand;
    logic               raise;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [RANK_W-1:0]  wr_data;
    stat_t              res_status;
    logic [INDEX_W-1:0] res_slot;
    logic [RANK_W-1:0]  res_value;
    logic               res_changed;

    // effective precision, clamped into the legal range
    always_comb
    begin
        if (EFF_W'(precision_reg) < EFF_MIN) begin
            eff_p = EFF_MIN;
        end else if (EFF_W'(precision_reg) > EFF_MAX) begin
            eff_p = EFF_MAX;
        end else begin
            eff_p = EFF_W'(precision_reg);
        end
    end

    assign max_rank   = RANK_W'(7'd65 - 7'(eff_p));
    assign peer_sat   = (peer_rank_reg > max_rank) ? max_rank : peer_rank_reg;
    assign slot_shift = 7'(HASH_W) - 7'(eff_p);

    // index/slot width adaptation
    assign idx_wide   = {{ADDR_W{1'b0}}, index_reg};
    assign idx_addr   = idx_wide[ADDR_W-1:0];
    assign hslot_wide = {{INDEX_W{1'b0}}, hslot_reg};
    assign hslot_out  = hslot_wide[INDEX_W-1:0];
    assign acc_addr   = (cmd_reg == CMD_ADD) ? hslot_reg : idx_addr;

    // merge/read rejection checks; mismatch is checked first
    assign mismatch     = (cmd_reg == CMD_MERGE) && (EFF_W'(peer_prec_reg) != eff_p);
    assign out_of_range = ((cmd_reg == CMD_MERGE) || (cmd_reg == CMD_READ))
                          && ((index_reg >> eff_p) != '0);
    assign bad          = mismatch || out_of_range;

    assign flags.bad      = bad;
    assign flags.clr_last = &clr_addr_reg;

    // shared 32x32 multiplier, operands picked by step
    assign mul_c = ctrl.mul_sel ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a = ctrl.mul_x1 ? k_reg[63:32] : k_reg[31:0];
    assign mul_b = ctrl.mul_x2 ? mul_c[63:32] : mul_c[31:0];
    assign mul_p = HASH_W'(mul_a) * HASH_W'(mul_b);

    // combine byte counts: first byte that is not all zero sets the rank
    always_comb
    begin
        rank_found = 1'b0;
        rank_calc  = max_rank;
        for (int i = 0; i < 8; i++) begin
            if (!rank_found && (byte_lz_reg[i] != 4'd8)) begin
                rank_found = 1'b1;
                rank_calc  = RANK_W'(i * 8) + RANK_W'(byte_lz_reg[i]) + RANK_W'(1);
            end
        end
    end

    // register update and result fields
    always_comb
    begin
        cand  = (cmd_reg == CMD_ADD) ? rank_reg : peer_sat;
        raise = ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_MERGE)) && !bad
                && (cand > rd_data_reg);
        res_status  = STAT_OK;
        res_slot    = '0;
        res_value   = '0;
        res_changed = 1'b0;
        case (cmd_reg)
            CMD_CLEAR: begin
                res_status = STAT_OK;
            end
            default: begin
                if (bad) begin
                    res_status = mismatch ? STAT_MISMATCH : STAT_RANGE;
                    res_slot   = index_reg;
                end else begin
                    res_slot    = (cmd_reg == CMD_ADD) ? hslot_out : index_reg;
                    res_value   = raise ? cand : rd_data_reg;
                    res_changed = raise;
                end
            end
        endcase
    end

    // single write port: clear sweep or register raise
    assign wr_en   = ctrl.clr_wr || (ctrl.finish && raise);
    assign wr_addr = ctrl.clr_wr ? clr_addr_reg : acc_addr;
    assign wr_data = ctrl.clr_wr ? '0 : cand;

    // rank store
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd) begin
            rd_data_reg <= mem[acc_addr];
        end
    end

    // control registers: precision and sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            precision_reg <= PRECISION_RESET;
            clr_addr_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                precision_reg <= cfg_wr_data;
            end
            if (ctrl.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // transaction capture, mixing, rank, results
    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            cmd_reg       <= cmd_t'(command);
            k_reg         <= hash;
            index_reg     <= index;
            peer_rank_reg <= peer_rank;
            peer_prec_reg <= peer_precision;
        end
        if (ctrl.xs) begin
            k_reg <= k_reg ^ (k_reg >> MIX_SHIFT);
        end
        if (ctrl.mul_lo) begin
            prod_reg <= mul_p;
        end
        if (ctrl.mul_x1) begin
            acc_reg  <= prod_reg;
            prod_reg <= mul_p;
        end
        if (ctrl.mul_x2) begin
            acc_reg  <= acc_reg + {prod_reg[31:0], 32'b0};
            prod_reg <= mul_p;
        end
        if (ctrl.mul_done) begin
            k_reg <= acc_reg + {prod_reg[31:0], 32'b0};
        end
        if (ctrl.shift) begin
            rest_reg  <= k_reg << eff_p;
            hslot_reg <= ADDR_W'(k_reg >> slot_shift);
        end
        if (ctrl.lz_bytes) begin
            for (int i = 0; i < 8; i++) begin
                byte_lz_reg[i] <= lzc8(rest_reg[63 - 8*i -: 8]);
            end
        end
        if (ctrl.lz_rank) begin
            rank_reg <= rank_calc;
        end
        if (ctrl.finish) begin
            status_reg  <= res_status;
            slot_reg    <= res_slot;
            value_reg   <= res_value;
            changed_reg <= res_changed;
        end
    end

    assign status  = status_reg;
    assign slot    = slot_reg;
    assign value   = value_reg;
    assign changed = changed_reg;

endmodule

// File: hw/rtl/hllru_ctrl.sv
// ----------------------------------------------------------------------------
// hllru_ctrl
// Sequencer: steps the datapath through mixing, ranking, store access and the
// clear sweep, and raises the result strobe.
// ----------------------------------------------------------------------------
module hllru_ctrl
    import hllru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  command,
    input  flags_t      flags,
    output ctrl_t       ctrl,
    output logic        busy,
    output logic        done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_XS,
        ST_MA,
        ST_MB,
        ST_MC,
        ST_MD,
        ST_SHIFT,
        ST_LZB,
        ST_LZR,
        ST_UPD
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] pass_reg;
    logic [1:0] pass_next;
    logic       from_cmd_reg;
    logic       from_cmd_next;
    logic       done_reg;
    logic       done_next;

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        from_cmd_next = from_cmd_reg;
        done_next     = 1'b0;
        ctrl          = '0;
        ctrl.mul_sel  = pass_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ctrl.load = 1'b1;
                    unique case (cmd_t'(command)) inside
                        CMD_ADD: begin
                            pass_next  = 2'd0;
                            state_next = ST_XS;
                        end
                        CMD_MERGE, CMD_READ: begin
                            state_next = ST_CHECK;
                        end
                        CMD_CLEAR: begin
                            from_cmd_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                ctrl.clr_wr = 1'b1;
                if (flags.clr_last) begin
                    ctrl.finish = from_cmd_reg;
                    done_next   = from_cmd_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (flags.bad) begin
                    ctrl.finish = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    ctrl.rd    = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_XS: begin
                ctrl.xs    = 1'b1;
                state_next = (pass_reg == 2'd2) ? ST_SHIFT : ST_MA;
            end
            ST_MA: begin
                ctrl.mul_lo = 1'b1;
                state_next  = ST_MB;
            end
            ST_MB: begin
                ctrl.mul_x1 = 1'b1;
                state_next  = ST_MC;
            end
            ST_MC: begin
                ctrl.mul_x2 = 1'b1;
                state_next  = ST_MD;
            end
            ST_MD: begin
                ctrl.mul_done = 1'b1;
                pass_next     = pass_reg + 2'd1;
                state_next    = ST_XS;
            end
            ST_SHIFT: begin
                ctrl.shift = 1'b1;
                state_next = ST_LZB;
            end
            ST_LZB: begin
                ctrl.lz_bytes = 1'b1;
                state_next    = ST_LZR;
            end
            ST_LZR: begin
                ctrl.lz_rank = 1'b1;
                ctrl.rd      = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                ctrl.finish = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered strobe; reset starts the store sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_CLEAR;
            pass_reg     <= 2'd0;
            from_cmd_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            from_cmd_reg <= from_cmd_next;
            done_reg     <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: verif/tb_hyperloglog_register_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hyperloglog_register_update
// Self-checking bench for the HLL register update block. A clocked driver
// feeds command transactions from a queue with random gaps. A scoreboard
// model predicts each result at acceptance, and a clocked monitor compares
// every done strobe field by field. The bench steps through several
// precision settings, the clamped extremes among them. Add hashes are often
// built by inverting the finalizer so that chosen slots and ranks come up.
// ----------------------------------------------------------------------------
module tb_hyperloglog_register_update;
    import hllru_pkg::*;

    localparam int STORE_DEPTH = 1 << DEF_MAX_PRECISION;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 95;

    // One command transaction as the sender sees it
    typedef struct {
        cmd_t              cmd;
        logic [HASH_W-1:0] hash;
        logic [INDEX_W-1:0] index;
        logic [RANK_W-1:0] peer_rank;
        logic [PREC_W-1:0] peer_prec;
        int                gap;
        bit                drain;
    } hll_cmd_t;

    // One result transaction
    typedef struct packed {
        stat_t              status;
        logic [INDEX_W-1:0] slot;
        logic [RANK_W-1:0]  value;
        logic               changed;
    } hll_result_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [1:0]          command        = CMD_READ;
    logic [HASH_W-1:0]   hash           = '0;
    logic [INDEX_W-1:0]  index          = '0;
    logic [RANK_W-1:0]   peer_rank      = '0;
    logic [PREC_W-1:0]   peer_precision = PRECISION_RESET;
    logic                cfg_wr_en      = 1'b0;
    logic [PREC_W-1:0]   cfg_wr_data    = PRECISION_RESET;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [INDEX_W-1:0]  slot;
    logic [RANK_W-1:0]   value;
    logic                changed;

    // Scoreboard state: model register file and precision
    logic [RANK_W-1:0]   rank_mem [STORE_DEPTH];
    logic [PREC_W-1:0]   sketch_prec = PRECISION_RESET;

    hll_cmd_t            cmd_q[$];
    hll_result_t         result_q[$];
    hll_cmd_t            cur_cmd;
    int                  gap_cnt        = 0;
    int                  queued_total   = 0;
    int                  accepted_total = 0;
    int                  mismatches     = 0;
    int                  calm_left      = 0;
    logic [INDEX_W-1:0]  hot_idx [32];

    hyperloglog_register_update u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .hash           (hash),
        .index          (index),
        .peer_rank      (peer_rank),
        .peer_precision (peer_precision),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .status         (status),
        .slot           (slot),
        .value          (value),
        .changed        (changed)
    );

    always #1 clk = ~clk;

    // Precision as the block uses it
    function automatic int eff_prec(logic [PREC_W-1:0] p);
        if (p < MIN_PRECISION)
            return MIN_PRECISION;
        if (p > DEF_MAX_PRECISION)
            return DEF_MAX_PRECISION;
        return int'(p);
    endfunction

    function automatic logic [HASH_W-1:0] mix64(logic [HASH_W-1:0] k);
        k = k ^ (k >> MIX_SHIFT);
        k = k * MIX_MUL_A;
        k = k ^ (k >> MIX_SHIFT);
        k = k * MIX_MUL_B;
        k = k ^ (k >> MIX_SHIFT);
        return k;
    endfunction

    function automatic int lead_zeros(logic [HASH_W-1:0] v);
        int n;
        n = 0;
        while (n < 64 && !v[63-n])
            n++;
        return n;
    endfunction

    // Inverse of an odd constant mod 2^64 by Newton iteration
    function automatic logic [HASH_W-1:0] inv_odd(logic [HASH_W-1:0] a);
        logic [HASH_W-1:0] x;
        x = a;
        repeat (5)
            x = x * (64'd2 - a * x);
        return x;
    endfunction

    // Key hash whose mixed value lands on slot with lz leading zeros in the
    // remainder; lz of 64-p gives an all-zero remainder
    function automatic logic [HASH_W-1:0] hash_for(logic [INDEX_W-1:0] sl, int lz, int p);
        logic [HASH_W-1:0] rest;
        logic [HASH_W-1:0] h;
        if (lz >= 64 - p)
            rest = '0;
        else
            rest = ({$urandom, $urandom} | 64'h8000_0000_0000_0000) >> lz;
        h = (64'(sl) << (64 - p)) | (rest >> p);
        // xor-shift by 33 undoes itself; multiplies undo by the inverses
        h = h ^ (h >> MIX_SHIFT);
        h = h * inv_odd(MIX_MUL_B);
        h = h ^ (h >> MIX_SHIFT);
        h = h * inv_odd(MIX_MUL_A);
        h = h ^ (h >> MIX_SHIFT);
        return h;
    endfunction

    // Scoreboard: apply one accepted command, return its result
    function automatic hll_result_t apply_command(hll_cmd_t c);
        int                 p;
        int                 top;
        int                 rank;
        logic [HASH_W-1:0]  h;
        logic [HASH_W-1:0]  rest;
        logic [RANK_W-1:0]  cur;
        logic [RANK_W-1:0]  peer;
        hll_result_t        r;
        p = eff_prec(sketch_prec);
        top = 65 - p;
        r.status = STAT_OK;
        r.slot = c.index;
        r.value = '0;
        r.changed = 1'b0;
        case (c.cmd)
            CMD_ADD:
            begin
                h = mix64(c.hash);
                r.slot = INDEX_W'(h >> (64 - p));
                rest = h << p;
                rank = (rest == 0) ? top : lead_zeros(rest) + 1;
                cur = rank_mem[r.slot];
                if (rank > int'(cur))
                begin
                    cur = RANK_W'(rank);
                    rank_mem[r.slot] = cur;
                    r.changed = 1'b1;
                end
                r.value = cur;
            end
            CMD_MERGE:
            begin
                if (int'(c.peer_prec) != p)
                    r.status = STAT_MISMATCH;
                else if (int'(c.index) >= (1 << p))
                    r.status = STAT_RANGE;
                else
                begin
                    peer = (int'(c.peer_rank) > top) ? RANK_W'(top) : c.peer_rank;
                    cur = rank_mem[c.index];
                    if (peer > cur)
                    begin
                        cur = peer;
                        rank_mem[c.index] = cur;
                        r.changed = 1'b1;
                    end
                    r.value = cur;
                end
            end
            CMD_READ:
            begin
                if (int'(c.index) >= (1 << p))
                    r.status = STAT_RANGE;
                else
                    r.value = rank_mem[c.index];
            end
            default:
            begin
                foreach (rank_mem[i])
                    rank_mem[i] = '0;
                r.slot = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < 200)
            $display("ERROR %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Append one transaction with its sender gap; calm stretches have none
    task automatic queue_cmd(cmd_t c, logic [HASH_W-1:0] h, logic [INDEX_W-1:0] idx,
                             logic [RANK_W-1:0] pr, logic [PREC_W-1:0] pp, bit drain);
        hll_cmd_t it;
        it.cmd = c;
        it.hash = h;
        it.index = idx;
        it.peer_rank = pr;
        it.peer_prec = pp;
        it.drain = drain;
        if (calm_left > 0)
        begin
            it.gap = 0;
            calm_left--;
        end
        else
        begin
            it.gap = $urandom_range(0, 17);
            if ($urandom_range(0, 29) == 0)
                calm_left = $urandom_range(10, 40);
        end
        cmd_q.push_back(it);
        queued_total++;
    endtask

    // Random mix, biased toward slots already touched
    task automatic queue_random(int n, int p);
        int                 sel;
        int                 k;
        bit                 crafted;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] sl;
        logic [HASH_W-1:0]  h;
        logic [PREC_W-1:0]  pp;
        cmd_t               c;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 5)
                idx = hot_idx[$urandom_range(0, 31)];
            else if (k < 8)
                idx = INDEX_W'($urandom_range(0, (1 << p) - 1));
            else
                idx = INDEX_W'($urandom);
            if (k < 6)
                sl = hot_idx[$urandom_range(0, 31)] & INDEX_W'((1 << p) - 1);
            else
                sl = INDEX_W'($urandom_range(0, (1 << p) - 1));
            crafted = ($urandom_range(0, 2) != 0);
            if (!crafted)
                h = {$urandom, $urandom};
            else if ($urandom_range(0, 1) == 0)
                h = hash_for(sl, $urandom_range(0, 3), p);
            else
                h = hash_for(sl, $urandom_range(0, 64 - p), p);
            pp = ($urandom_range(0, 3) != 0) ? PREC_W'(p) : PREC_W'($urandom_range(0, 15));
            sel = $urandom_range(0, 999);
            if (sel < 4)
                c = CMD_CLEAR;
            else if (sel < 450)
                c = CMD_ADD;
            else if (sel < 750)
                c = CMD_MERGE;
            else
                c = CMD_READ;
            if (c == CMD_MERGE)
                hot_idx[$urandom_range(0, 31)] = idx;
            else if (c == CMD_ADD && crafted)
                hot_idx[$urandom_range(0, 31)] = sl;
            queue_cmd(c, h, idx, RANK_W'($urandom_range(0, 61)), pp,
                      $urandom_range(0, 59) == 0);
        end
    endtask

    // Block idle and every queued transaction answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (accepted_total != queued_total || result_q.size() != 0 || busy);
    endtask

    // Driver: present queued transactions, predict at acceptance
    always @(posedge clk or negedge rst_n)
    begin : driver
        hll_cmd_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                result_q.push_back(apply_command(cur_cmd));
                accepted_total++;
            end
            if (!start || !busy)
            begin
                if (cmd_q.size() != 0 && gap_cnt >= cmd_q[0].gap &&
                    !(cmd_q[0].drain && result_q.size() != 0))
                begin
                    nxt = cmd_q.pop_front();
                    cur_cmd <= nxt;
                    command <= nxt.cmd;
                    hash <= nxt.hash;
                    index <= nxt.index;
                    peer_rank <= nxt.peer_rank;
                    peer_precision <= nxt.peer_prec;
                    start <= 1'b1;
                    gap_cnt <= 0;
                end
                else
                begin
                    start <= 1'b0;
                    if (cmd_q.size() != 0)
                        gap_cnt <= gap_cnt + 1;
                end
            end
        end
    end

    // Monitor: each done strobe against the oldest prediction
    always @(posedge clk)
    begin : monitor
        hll_result_t want;
        if (rst_n && done)
        begin
            if (result_q.size() == 0)
                report_mismatch("result with no transaction outstanding, slot", slot, 0);
            else
            begin
                want = result_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (slot !== want.slot)
                    report_mismatch("slot", slot, want.slot);
                if (value !== want.value)
                    report_mismatch("value", value, want.value);
                if (changed !== want.changed)
                    report_mismatch("changed", changed, want.changed);
            end
        end
    end

    // Stimulus and configuration phases
    initial
    begin : stimulus
        logic [PREC_W-1:0] phase_prec [NUM_PHASES];
        int p;
        phase_prec = '{4'd14, 4'd4, 4'd0, 4'd15, 4'd9, 4'd5, 4'd12, 4'd14, 4'd7, 4'd2};
        foreach (rank_mem[i])
            rank_mem[i] = '0;
        foreach (hot_idx[i])
            hot_idx[i] = INDEX_W'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // post-reset sweep keeps busy high
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= phase_prec[ph];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            sketch_prec = phase_prec[ph];
            p = eff_prec(phase_prec[ph]);

            case (ph)
                0:
                begin
                    // hash zero mixes to zero: empty remainder, top rank
                    queue_cmd(CMD_ADD, 64'd0, 0, 0, 0, 0);
                    queue_cmd(CMD_ADD, '1, '1, '1, '1, 0);
                    queue_cmd(CMD_ADD, hash_for(14'h3fff, 64, p), 0, 0, 0, 0);
                    queue_cmd(CMD_ADD, hash_for(14'd100, 0, p), 0, 0, 0, 0);
                    queue_cmd(CMD_READ, 0, 14'h3fff, 0, 0, 0);
                    // peer rank above the cap saturates
                    queue_cmd(CMD_MERGE, 0, 14'd16000, 6'd61, 4'd14, 0);
                    queue_cmd(CMD_MERGE, 0, 14'h3fff, 6'd3, 4'd4, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd5, 6'd3, 4'd15, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd5, 6'd3, 4'd14, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd5, 6'd2, 4'd14, 0);
                    queue_cmd(CMD_READ, 0, 14'd5, 0, 0, 0);
                    // clear only after the pipe has drained
                    queue_cmd(CMD_CLEAR, 0, 0, 0, 0, 1);
                    queue_cmd(CMD_READ, 0, 14'h3fff, 0, 0, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd9000, 6'd7, 4'd14, 0);
                end
                1:
                begin
                    queue_cmd(CMD_READ, 0, 14'd15, 0, 0, 0);
                    queue_cmd(CMD_READ, 0, 14'd16, 0, 0, 0);
                    // mismatch wins over out of range
                    queue_cmd(CMD_MERGE, 0, 14'd20, 6'd5, 4'd5, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd16, 6'd5, 4'd4, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd3, 6'd61, 4'd4, 0);
                    queue_cmd(CMD_ADD, hash_for(14'd0, 64, p), 0, 0, 0, 0);
                    // entry written at high precision is out of reach now
                    queue_cmd(CMD_READ, 0, 14'd9000, 0, 0, 0);
                end
                2:
                begin
                    // precision below range acts as the minimum
                    queue_cmd(CMD_MERGE, 0, 14'd2, 6'd9, 4'd4, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd2, 6'd9, 4'd0, 0);
                end
                3:
                begin
                    // precision above range acts as the maximum
                    queue_cmd(CMD_READ, 0, 14'd9000, 0, 0, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd9000, 6'd60, 4'd15, 0);
                    queue_cmd(CMD_MERGE, 0, 14'd9000, 6'd60, 4'd14, 0);
                end
                default:
                begin
                end
            endcase

            queue_random(PHASE_ITEMS, p);
            wait_drained();
        end

        // let any stray strobe show up
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
